@@ sv/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg: shared types and constants for the wheel odometry block
// Beat layouts, controller commands, op codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none
package odo_pkg;

	// widths of the serial multiply/divide unit
	localparam int NUM_W  = 104;
	localparam int DIV_W  = 64;
	localparam int MCNT_W = 7;

	// width of dl+dr and dr-dl, and of the magnitude of r times either
	localparam int SUM_W = 34;
	localparam int MAG_W = 54;

	localparam int                 C_BITS      = 46;
	localparam logic [C_BITS-1:0]  TURN_TO_BAM = 46'd44798133900178;
	localparam int                 MICRO_BITS  = 20;
	localparam logic [19:0]        MICRO       = 20'd1000000;
	localparam int                 Q30_BITS    = 31;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP    = 2'd1;

	localparam logic [19:0] RADIUS_RST = 20'd33000;
	localparam logic [23:0] SEP_RST    = 24'd170000;

	// operations of the shared arithmetic unit, in issue order
	localparam logic [2:0] OP_HEAD = 3'd0;
	localparam logic [2:0] OP_MULX = 3'd1;
	localparam logic [2:0] OP_MULY = 3'd2;
	localparam logic [2:0] OP_LIN  = 3'd3;
	localparam logic [2:0] OP_ANG  = 3'd4;

	typedef struct packed {
		logic signed [31:0] left_wheel_angle;
		logic signed [31:0] right_wheel_angle;
		logic [31:0]        sample_time_us;
	} sample_t;

	typedef struct packed {
		logic signed [47:0] pos_x_um;
		logic signed [47:0] pos_y_um;
		logic [31:0]        heading_angle;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
		logic signed [31:0] linear_speed;
		logic signed [31:0] angular_speed;
		logic               zero_interval_flag;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       start;
		logic       apply;
		logic       cordic_start;
		logic       out_load;
		logic [2:0] op;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
		logic cordic_done;
		logic sep_zero;
		logic dt_zero;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// clip a quotient magnitude to the signed 32 bit range and apply the sign
	function automatic logic [31:0] sat32(input logic [NUM_W-1:0] q, input logic neg);
		logic [NUM_W-1:0] lim;
		logic [31:0]      m;
		lim = neg ? NUM_W'(33'h080000000) : NUM_W'(32'h7FFFFFFF);
		m   = (q > lim) ? lim[31:0] : q[31:0];
		return neg ? (32'd0 - m) : m;
	endfunction

endpackage
`default_nettype wire

@@ sv/odo_ifs.sv @@
// ----------------------------------------------------------------------------
// odo channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface odo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_wheel_angle;
	logic signed [31:0] right_wheel_angle;
	logic [31:0]        sample_time_us;
	modport source (output valid, left_wheel_angle, right_wheel_angle, sample_time_us,
		input ready);
	modport sink (input valid, left_wheel_angle, right_wheel_angle, sample_time_us,
		output ready);
endinterface

interface odo_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] pos_x_um;
	logic signed [47:0] pos_y_um;
	logic [31:0]        heading_angle;
	logic signed [31:0] quat_z;
	logic signed [31:0] quat_w;
	logic signed [31:0] linear_speed;
	logic signed [31:0] angular_speed;
	logic               zero_interval_flag;
	modport source (output valid, pos_x_um, pos_y_um, heading_angle, quat_z, quat_w,
		linear_speed, angular_speed, zero_interval_flag, input ready);
	modport sink (input valid, pos_x_um, pos_y_um, heading_angle, quat_z, quat_w,
		linear_speed, angular_speed, zero_interval_flag, output ready);
endinterface

interface odo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/odo_muldiv.sv @@
// ----------------------------------------------------------------------------
// odo_muldiv: bit-serial multiply, add and divide unit
// result = (a*b + addend) / d, or a*b + addend without the divide.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_muldiv (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire                            do_div,
	input  wire  [odo_pkg::NUM_W-1:0]      a,
	input  wire  [odo_pkg::DIV_W-1:0]      b,
	input  wire  [odo_pkg::MCNT_W-1:0]     nb,
	input  wire  [odo_pkg::NUM_W-1:0]      addend,
	input  wire  [odo_pkg::DIV_W-1:0]      d,
	output logic                           done,
	output logic [odo_pkg::NUM_W-1:0]      result
);
	import odo_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_ADD  = 2'd2;
	localparam logic [1:0] PH_DIV  = 2'd3;

	logic [1:0]        phase_q;
	logic              done_q;
	logic [NUM_W-1:0]  a_q, add_q, acc_q;
	logic [DIV_W-1:0]  b_q, d_q, rem_q;
	logic [MCNT_W-1:0] cnt_q;
	logic              div_q;
	logic [DIV_W-1:0]  trial;
	logic              fits;

	assign trial  = {rem_q[DIV_W-2:0], acc_q[NUM_W-1]};
	assign fits   = trial >= d_q;
	assign done   = done_q;
	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_MUL;
				PH_MUL:  if (cnt_q == '0) phase_q <= PH_ADD;
				PH_ADD: begin
					if (div_q) begin
						phase_q <= PH_DIV;
					end else begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				PH_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					a_q   <= a;
					b_q   <= b;
					add_q <= addend;
					d_q   <= d;
					div_q <= do_div;
					acc_q <= '0;
					cnt_q <= nb - MCNT_W'(1);
				end
			end
			PH_MUL: begin
				// shift-add, multiplier bits taken from the top
				acc_q <= {acc_q[NUM_W-2:0], 1'b0} + (b_q[cnt_q[5:0]] ? a_q : '0);
				cnt_q <= cnt_q - MCNT_W'(1);
			end
			PH_ADD: begin
				acc_q <= acc_q + add_q;
				rem_q <= '0;
				cnt_q <= MCNT_W'(NUM_W - 1);
			end
			PH_DIV: begin
				// restoring divide, quotient shifts in behind the numerator
				rem_q <= fits ? (trial - d_q) : trial;
				acc_q <= {acc_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - MCNT_W'(1);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/odo_cordic.sv @@
// ----------------------------------------------------------------------------
// odo_cordic: iterative rotation-mode CORDIC
// Cosine and sine of a binary angle in Q1.30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_cordic #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire  [31:0]        angle,
	output logic               done,
	output logic signed [31:0] cos_q30,
	output logic signed [31:0] sin_q30
);
	import odo_pkg::*;

	localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

	logic               busy_q, done_q, flip_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] xs, ys, at, xc, yc, xo, yo;
	logic [31:0]        rot, a2;
	logic               flip;

	assign rot  = angle + 32'h40000000;
	assign flip = rot[31];
	assign a2   = flip ? (angle + 32'h80000000) : angle;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = $signed({2'b00, atan_bam(5'(cnt_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({{2{a2[31]}}, a2});
			flip_q <= flip;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// clamp to unit magnitude, undo the half-turn pre-rotation
	always_comb begin
		xc = (x_q > ONE_Q30) ? ONE_Q30 : ((x_q < -ONE_Q30) ? -ONE_Q30 : x_q);
		yc = (y_q > ONE_Q30) ? ONE_Q30 : ((y_q < -ONE_Q30) ? -ONE_Q30 : y_q);
		xo = flip_q ? -xc : xc;
		yo = flip_q ? -yc : yc;
	end

	assign cos_q30 = xo[31:0];
	assign sin_q30 = yo[31:0];
	assign done    = done_q;
endmodule
`default_nettype wire

@@ sv/odo_dp.sv @@
// ----------------------------------------------------------------------------
// odo_dp: odometry datapath
// Pose and history state, configuration, operand selection, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_dp #(
	parameter int CORDIC_STEPS    = 24,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  odo_pkg::sample_t             smp,
	input  wire                                cfg_we,
	input  wire  [odo_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire  [odo_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire  odo_pkg::cmd_t                cmd,
	output odo_pkg::stat_t                     stat,
	output logic                               out_valid,
	input  wire                                out_ready,
	output odo_pkg::result_t                   res
);
	import odo_pkg::*;

	localparam int F = ANGLE_FRAC_BITS;

	logic [19:0]             radius_q;
	logic [23:0]             sep_q;
	logic [31:0]             last_left_q, last_right_q, last_time_q, heading_q;
	logic [47:0]             acc_x_q, acc_y_q;
	logic signed [SUM_W-1:0] sum_q, dif_q;
	logic [31:0]             dt_q, lin_q, ang_q;
	logic [MAG_W-1:0]        ms_q, md_q;
	logic                    ps_neg_q, pd_neg_q;
	logic [55:0]             sepdt_q;
	logic                    out_valid_q;
	result_t                 res_q;

	logic signed [32:0]      dl, dr;
	logic signed [54:0]      ps, pd;
	logic [MAG_W:0]          ds_sum, ds_mag;
	logic signed [31:0]      hc, hs, qc, qs;
	logic                    c_done, s_done;
	logic [31:0]             c_mag, s_mag, step;
	logic [47:0]             m48;
	logic                    mul_neg;

	logic [NUM_W-1:0]        u_a, u_add, u_res;
	logic [DIV_W-1:0]        u_b, u_d;
	logic [MCNT_W-1:0]       u_nb;
	logic                    u_div, u_done;

	assign dl = $signed({smp.left_wheel_angle[31], smp.left_wheel_angle})
		- $signed({last_left_q[31], last_left_q});
	assign dr = $signed({smp.right_wheel_angle[31], smp.right_wheel_angle})
		- $signed({last_right_q[31], last_right_q});

	assign ps = $signed({1'b0, radius_q}) * sum_q;
	assign pd = $signed({1'b0, radius_q}) * dif_q;

	assign ds_sum = {1'b0, ms_q} + ((MAG_W + 1)'(1) << F);
	assign ds_mag = ds_sum >> (F + 1);

	// both rotations run side by side: full heading and half heading
	odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_head (
		.clk(clk), .arst_n(arst_n), .start(cmd.cordic_start), .angle(heading_q),
		.done(c_done), .cos_q30(hc), .sin_q30(hs)
	);

	odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_half (
		.clk(clk), .arst_n(arst_n), .start(cmd.cordic_start),
		.angle({1'b0, heading_q[31:1]}),
		.done(s_done), .cos_q30(qc), .sin_q30(qs)
	);

	assign c_mag = hc[31] ? (32'd0 - hc) : hc;
	assign s_mag = hs[31] ? (32'd0 - hs) : hs;

	always_comb begin
		u_a   = '0;
		u_b   = '0;
		u_nb  = MCNT_W'(1);
		u_add = '0;
		u_d   = DIV_W'(1);
		u_div = 1'b0;
		case (cmd.op)
			OP_HEAD: begin
				u_a   = NUM_W'(md_q);
				u_b   = DIV_W'(TURN_TO_BAM);
				u_nb  = MCNT_W'(C_BITS);
				u_add = NUM_W'(sep_q) << (F + 15);
				u_d   = DIV_W'(sep_q);
				u_div = 1'b1;
			end
			OP_MULX: begin
				u_a   = NUM_W'(ds_mag);
				u_b   = DIV_W'(c_mag[Q30_BITS-1:0]);
				u_nb  = MCNT_W'(Q30_BITS);
				u_add = NUM_W'(1) << 29;
			end
			OP_MULY: begin
				u_a   = NUM_W'(ds_mag);
				u_b   = DIV_W'(s_mag[Q30_BITS-1:0]);
				u_nb  = MCNT_W'(Q30_BITS);
				u_add = NUM_W'(1) << 29;
			end
			OP_LIN: begin
				u_a   = NUM_W'(ms_q);
				u_b   = DIV_W'(MICRO);
				u_nb  = MCNT_W'(MICRO_BITS);
				u_add = NUM_W'(dt_q) << F;
				u_d   = DIV_W'(dt_q);
				u_div = 1'b1;
			end
			OP_ANG: begin
				u_a   = NUM_W'(md_q) << 16;
				u_b   = DIV_W'(MICRO);
				u_nb  = MCNT_W'(MICRO_BITS);
				u_add = NUM_W'(sepdt_q) << (F - 1);
				u_d   = DIV_W'(sepdt_q);
				u_div = 1'b1;
			end
			default: ;
		endcase
	end

	odo_muldiv u_muldiv (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .do_div(u_div),
		.a(u_a), .b(u_b), .nb(u_nb), .addend(u_add), .d(u_d),
		.done(u_done), .result(u_res)
	);

	assign step    = 32'(u_res >> (F + 16));
	assign m48     = 48'(u_res >> 30);
	assign mul_neg = ps_neg_q ^ ((cmd.op == OP_MULX) ? hc[31] : hs[31]);

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RST;
			sep_q        <= SEP_RST;
			last_left_q  <= '0;
			last_right_q <= '0;
			last_time_q  <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			heading_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_RADIUS: radius_q <= cfg_data[19:0];
					REG_SEP:    sep_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_left_q  <= smp.left_wheel_angle;
				last_right_q <= smp.right_wheel_angle;
				last_time_q  <= smp.sample_time_us;
			end
			if (cmd.apply) begin
				case (cmd.op)
					OP_HEAD: heading_q <= heading_q + (pd_neg_q ? (32'd0 - step) : step);
					OP_MULX: acc_x_q <= acc_x_q + (mul_neg ? (48'd0 - m48) : m48);
					OP_MULY: acc_y_q <= acc_y_q + (mul_neg ? (48'd0 - m48) : m48);
					default: ;
				endcase
			end
		end
	end

	// per-sample working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= {dl[32], dl} + {dr[32], dr};
			dif_q <= {dr[32], dr} - {dl[32], dl};
			dt_q  <= smp.sample_time_us - last_time_q;
			lin_q <= '0;
			ang_q <= '0;
		end
		if (cmd.prep) begin
			ms_q     <= ps[54] ? MAG_W'(-ps) : MAG_W'(ps);
			md_q     <= pd[54] ? MAG_W'(-pd) : MAG_W'(pd);
			ps_neg_q <= ps[54];
			pd_neg_q <= pd[54];
			sepdt_q  <= sep_q * dt_q;
		end
		if (cmd.apply) begin
			case (cmd.op)
				OP_LIN: lin_q <= sat32(u_res >> (F + 1), ps_neg_q);
				OP_ANG: ang_q <= sat32(u_res >> F, pd_neg_q);
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			res_q.pos_x_um           <= acc_x_q;
			res_q.pos_y_um           <= acc_y_q;
			res_q.heading_angle      <= heading_q;
			res_q.quat_z             <= qs;
			res_q.quat_w             <= qc;
			res_q.linear_speed       <= lin_q;
			res_q.angular_speed      <= ang_q;
			res_q.zero_interval_flag <= (dt_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.unit_done   = u_done;
	assign stat.cordic_done = c_done & s_done;
	assign stat.sep_zero    = (sep_q == '0);
	assign stat.dt_zero     = (dt_q == '0);
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

@@ sv/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// odo_ctrl: odometry sequencer
// Steps one sample through the shared arithmetic unit and the CORDIC pair.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  odo_pkg::stat_t stat,
	output odo_pkg::cmd_t        cmd
);
	import odo_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_CORD  = 3'd4;
	localparam logic [2:0] ST_CWAIT = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q, state_d, op_q, op_d, nxt_st, nxt_op;
	logic       skip;

	// where to go once the current op is finished or skipped
	always_comb begin
		nxt_op = op_q + 3'd1;
		case (op_q)
			OP_HEAD: nxt_st = ST_CORD;
			OP_ANG:  nxt_st = ST_DONE;
			default: nxt_st = ST_ISSUE;
		endcase
		case (op_q)
			OP_HEAD: skip = stat.sep_zero;
			OP_LIN:  skip = stat.dt_zero;
			OP_ANG:  skip = stat.dt_zero || stat.sep_zero;
			default: skip = 1'b0;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = op_q;
		state_d  = state_q;
		op_d     = op_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				op_d     = OP_HEAD;
				state_d  = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (skip) begin
					state_d = nxt_st;
					op_d    = nxt_op;
				end else begin
					cmd.start = 1'b1;
					state_d   = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.unit_done) begin
					cmd.apply = 1'b1;
					state_d   = nxt_st;
					op_d      = nxt_op;
				end
			end
			ST_CORD: begin
				cmd.cordic_start = 1'b1;
				state_d          = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (stat.cordic_done) begin
					op_d    = OP_MULX;
					state_d = ST_ISSUE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_HEAD;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end
endmodule
`default_nettype wire

@@ sv/diff_drive_wheel_odometry.sv @@
// ----------------------------------------------------------------------------
// diff_drive_wheel_odometry: differential-drive wheel odometry
// Integrates wheel angle samples into pose, yaw quaternion and speeds.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one beat per encoder reading (left/right angle Q16.16 rad, time us).
//   result : one beat per sample: x/y in um, binary heading, quaternion z/w
//            (Q1.30), linear um/s and angular Q16.16 rad/s (saturated) and a
//            flag when the timestamp did not advance (speeds then read zero).
//   cfg    : register writes, always ready; index 0 wheel radius um, index 1
//            wheel separation um. Write only while no sample is in flight.
// Throughput: one sample at a time; the next sample can be taken in the
// cycle after the previous result beat loads into the output register. Zero
// dt, zero separation or both skip divides. The bit-serial multiply/divide
// unit takes one 104-bit numerator bit per divide cycle, and the paired
// CORDIC engines rotate the full and the half heading side by side.
// Reset clears the pose, heading and the previous sample (angles and time),
// and loads the default wheel geometry. A stalled receiver holds the result
// beat in the output register; the next sample is accepted and processed
// meanwhile, then waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none
module diff_drive_wheel_odometry #(
	parameter int CORDIC_STEPS    = 24,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	odo_sample_if.sink   sample,
	odo_result_if.source result,
	odo_cfg_if.sink      cfg
);
	import odo_pkg::*;

	sample_t smp;
	result_t res;
	cmd_t    cmd;
	stat_t   stat;
	logic    in_ready;
	logic    out_valid;

	// unpack the sample beat
	assign smp.left_wheel_angle  = sample.left_wheel_angle;
	assign smp.right_wheel_angle = sample.right_wheel_angle;
	assign smp.sample_time_us    = sample.sample_time_us;
	assign sample.ready          = in_ready;

	// registers take a write in any cycle
	assign cfg.ready = 1'b1;

	odo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(sample.valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	odo_dp #(
		.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .smp(smp),
		.cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
		.cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_ready(result.ready), .res(res)
	);

	// drive the result beat from the output register
	assign result.valid              = out_valid;
	assign result.pos_x_um           = res.pos_x_um;
	assign result.pos_y_um           = res.pos_y_um;
	assign result.heading_angle      = res.heading_angle;
	assign result.quat_z             = res.quat_z;
	assign result.quat_w             = res.quat_w;
	assign result.linear_speed       = res.linear_speed;
	assign result.angular_speed      = res.angular_speed;
	assign result.zero_interval_flag = res.zero_interval_flag;
endmodule
`default_nettype wire
